### sv/rgbp_pkg.sv
package rgbp_pkg;

  // slab alignment in bytes, a power of two
  localparam int unsigned SlabAlign   = 64;
  localparam logic [49:0] SlabLowMask = 50'(SlabAlign - 1);

  localparam logic [32:0] Max33 = {33{1'b1}};
  localparam logic [39:0] Max40 = {40{1'b1}};
  localparam logic [47:0] Max48 = {48{1'b1}};
  // a saturated slab sum rounded up to the alignment
  localparam logic [48:0] Max48Aligned = {1'b1, 48'd0};

  localparam int unsigned NumStringPorts = 8;

  // item-set queue between the packing decision and the record sequencer
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic KindPlace = 1'b0;
  localparam logic KindClose = 1'b1;

  typedef enum logic [1:0] {
    CFG_BATCH_LIMIT  = 2'd0,
    CFG_STRING_LIMIT = 2'd1,
    CFG_ACTIVE_COLS  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_PRE   = 3'b001,
    PH_PLACE = 3'b010,
    PH_POST  = 3'b100
  } phase_e;

  // per-cycle control from the merge stage to every column lane
  typedef struct packed {
    logic take;
    logic cut;
    logic clear;
  } lane_ctrl_t;

  // everything the sequencer needs to emit the records of one item
  typedef struct packed {
    logic        cut;
    logic        post;
    logic [31:0] cnt_pre;
    logic [39:0] row_pre;
    logic [47:0] slab_pre;
    logic [39:0] row_new;
    logic [47:0] slab_new;
  } bundle_set_t;

endpackage

### sv/rgbp_lane.sv
module rgbp_lane import rgbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] string_bytes_i,
  input  logic [31:0] string_limit_i,
  input  lane_ctrl_t  ctrl_i,
  output logic        hit_o
);

  logic [32:0] sum_q, sum_d;
  logic [33:0] sum_ext;

  assign sum_ext = {1'b0, sum_q} + {2'b00, string_bytes_i};
  assign hit_o   = sum_ext >= {2'b00, string_limit_i};

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.take) begin
      if (ctrl_i.clear) begin
        sum_d = '0;
      end else if (ctrl_i.cut) begin
        sum_d = {1'b0, string_bytes_i};
      end else begin
        sum_d = sum_ext[33] ? Max33 : sum_ext[32:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

endmodule

### sv/rgbp_merge.sv
module rgbp_merge import rgbp_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  logic [31:0]            decoded_bytes_i,
  input  logic [23:0]            group_rows_i,
  input  logic [31:0]            staging_bytes_i,
  input  logic                   final_group_i,
  input  logic [47:0]            batch_limit_i,
  input  logic [3:0]             active_cols_i,
  input  logic [MAX_COLUMNS-1:0] lane_hit_i,
  output lane_ctrl_t             lane_ctrl_o,
  output bundle_set_t            set_o
);

  logic        open_q, open_d;
  logic [47:0] budget_q, budget_d;
  logic [39:0] row_q, row_d;
  logic [47:0] slab_q, slab_d;
  logic [31:0] cnt_q, cnt_d;

  logic [MAX_COLUMNS-1:0] active_mask;
  logic [48:0] budget_ext;
  logic        over;
  logic        cut;
  logic [47:0] budget_new;
  logic [40:0] row_ext;
  logic [39:0] row_new;
  logic [47:0] slab_start;
  logic [49:0] slab_raw, slab_up;
  logic [47:0] slab_new;
  logic        post;
  logic [31:0] cnt_place;

  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      active_mask[c] = 4'(c) < active_cols_i;
    end
  end

  assign budget_ext = {1'b0, budget_q} + {17'd0, decoded_bytes_i};
  assign over       = budget_ext > {1'b0, batch_limit_i};
  assign cut        = open_q & (over | (|(lane_hit_i & active_mask)));

  assign budget_new = cut ? {16'd0, decoded_bytes_i}
                          : (budget_ext[48] ? Max48 : budget_ext[47:0]);

  assign row_ext = {1'b0, row_q} + {17'd0, group_rows_i};
  assign row_new = cut ? {16'd0, group_rows_i}
                       : (row_ext[40] ? Max40 : row_ext[39:0]);

  // slab grows to the next aligned boundary after this group's staging bytes
  assign slab_start = cut ? '0 : slab_q;
  assign slab_raw   = {2'b00, slab_start} + {18'd0, staging_bytes_i} + SlabLowMask;
  assign slab_up    = slab_raw & ~SlabLowMask;
  assign slab_new   = (slab_up > {2'b00, Max48}) ? Max48 : slab_up[47:0];

  // a row count that is not a multiple of 8, or a request end, closes right after the placement
  assign post      = (row_new[2:0] != 3'd0) | final_group_i;
  assign cnt_place = cnt_q + 32'(cut);

  always_comb begin
    open_d   = open_q;
    budget_d = budget_q;
    row_d    = row_q;
    slab_d   = slab_q;
    cnt_d    = cnt_q;
    if (take_i) begin
      open_d = ~post;
      if (post) begin
        budget_d = '0;
        row_d    = '0;
        slab_d   = '0;
      end else begin
        budget_d = budget_new;
        row_d    = row_new;
        slab_d   = slab_new;
      end
      cnt_d = final_group_i ? '0 : cnt_place + 32'(post);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      budget_q <= '0;
      row_q    <= '0;
      slab_q   <= '0;
      cnt_q    <= '0;
    end else begin
      open_q   <= open_d;
      budget_q <= budget_d;
      row_q    <= row_d;
      slab_q   <= slab_d;
      cnt_q    <= cnt_d;
    end
  end

  assign lane_ctrl_o.take  = take_i;
  assign lane_ctrl_o.cut   = cut;
  assign lane_ctrl_o.clear = post;

  assign set_o.cut      = cut;
  assign set_o.post     = post;
  assign set_o.cnt_pre  = cnt_q;
  assign set_o.row_pre  = row_q;
  assign set_o.slab_pre = slab_q;
  assign set_o.row_new  = row_new;
  assign set_o.slab_new = slab_new;

  a_closed_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (budget_q == '0 && row_q == '0 && slab_q == '0))
    else $error("closed bundle holds nonzero sums");

  a_post_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && post |=> !open_q)
    else $error("bundle still open after a closing item");

  a_final_resets_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && final_group_i |=> cnt_q == '0)
    else $error("bundle counter not cleared at request end");

endmodule

### sv/rgbp_out.sv
module rgbp_out import rgbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  bundle_set_t set_i,
  output logic        full_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_kind_o,
  output logic [31:0] bundle_number_o,
  output logic [39:0] row_bit_offset_o,
  output logic [47:0] slab_pos_o,
  output logic [39:0] bundle_rows_o,
  output logic [35:0] mask_words_o,
  output logic [47:0] bundle_bytes_o,
  output logic        last_of_run_o
);

  bundle_set_t q_mem [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;
  phase_e           phase_q, phase_d;
  logic             out_valid_q, out_valid_d;

  bundle_set_t head;
  logic        have;
  phase_e      cur_ph;
  logic        last;
  logic        load;
  logic        pop;
  logic [31:0] cnt_place;

  logic [39:0] cl_rows;
  logic [47:0] cl_slab;
  logic [40:0] words_ext;
  logic [35:0] words;
  logic [48:0] slab_aligned;
  logic [49:0] bytes_ext;
  logic [47:0] bytes;

  logic        kind_d;
  logic [31:0] num_d;
  logic [39:0] rbo_d;
  logic [47:0] so_d;
  logic [39:0] rows_d;
  logic [35:0] mw_d;
  logic [47:0] bb_d;

  assign head   = q_mem[rd_ptr_q];
  assign have   = count_q != '0;
  assign full_o = count_q == QCntW'(QueueDepth);

  // a pending close-before is skipped when the item did not cut
  always_comb begin
    if (phase_q == PH_PRE && head.cut) begin
      cur_ph = PH_PRE;
    end else if (phase_q == PH_POST) begin
      cur_ph = PH_POST;
    end else begin
      cur_ph = PH_PLACE;
    end
  end

  assign last = (cur_ph == PH_POST) || (cur_ph == PH_PLACE && !head.post);
  assign load = have && (!out_valid_q || !out_stall_i);
  assign pop  = load && last;

  assign cnt_place = head.cnt_pre + 32'(head.cut);

  // close record arithmetic: slab sums are aligned unless saturated
  assign cl_rows      = (cur_ph == PH_PRE) ? head.row_pre  : head.row_new;
  assign cl_slab      = (cur_ph == PH_PRE) ? head.slab_pre : head.slab_new;
  assign words_ext    = {1'b0, cl_rows} + 41'd31;
  assign words        = words_ext[40:5];
  assign slab_aligned = (cl_slab == Max48) ? Max48Aligned : {1'b0, cl_slab};
  assign bytes_ext    = {1'b0, slab_aligned} + {12'd0, words, 2'b00};
  assign bytes        = (bytes_ext > {2'b00, Max48}) ? Max48 : bytes_ext[47:0];

  always_comb begin
    kind_d = KindPlace;
    num_d  = cnt_place;
    rbo_d  = '0;
    so_d   = '0;
    rows_d = '0;
    mw_d   = '0;
    bb_d   = '0;
    case (cur_ph)
      PH_PRE: begin
        kind_d = KindClose;
        num_d  = head.cnt_pre;
        rows_d = cl_rows;
        mw_d   = words;
        bb_d   = bytes;
      end
      PH_POST: begin
        kind_d = KindClose;
        num_d  = cnt_place;
        rows_d = cl_rows;
        mw_d   = words;
        bb_d   = bytes;
      end
      default: begin
        kind_d = KindPlace;
        num_d  = cnt_place;
        rbo_d  = head.cut ? '0 : head.row_pre;
        so_d   = head.cut ? '0 : head.slab_pre;
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    if (load) begin
      if (last) begin
        phase_d = PH_PRE;
      end else if (cur_ph == PH_PRE) begin
        phase_d = PH_PLACE;
      end else begin
        phase_d = PH_POST;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign count_d = count_q + QCntW'(push_i) - QCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      phase_q     <= PH_PRE;
      out_valid_q <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q     <= count_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_ptr_q] <= set_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      record_kind_o    <= kind_d;
      bundle_number_o  <= num_d;
      row_bit_offset_o <= rbo_d;
      slab_pos_o       <= so_d;
      bundle_rows_o    <= rows_d;
      mask_words_o     <= mw_d;
      bundle_bytes_o   <= bb_d;
      last_of_run_o    <= last;
    end
  end

  assign out_valid_o = out_valid_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QueueDepth))
    else $error("item queue count beyond depth");

  a_mid_item_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_PRE |-> count_q != '0)
    else $error("sequencer mid-item with empty queue");

  a_post_only_if_closing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_POST |-> head.post)
    else $error("close-after emitted for an item that does not close");

endmodule

### sv/row_group_bundle_packer_core.sv
// with nothing queued ahead, an accepted item is written into the item queue, and its
//   first record is then loaded from the queue head into the output register
// throughput: one item per cycle into a four-entry item queue while not full; the output
//   emits one record per cycle unless stalled; per item a placement and optional closes
// reset (rst_ni low, async): bundle closed, all sums and the bundle counter zero, queue empty,
//   limits back to 268435456 bytes, 2147483647 string bytes and 8 active columns
module row_group_bundle_packer_core import rgbp_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_wdata_i,

  // row-group descriptor items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] decoded_bytes_i,
  input  logic [23:0] group_rows_i,
  input  logic [31:0] staging_bytes_i,
  input  logic [31:0] string_bytes_0_i,
  input  logic [31:0] string_bytes_1_i,
  input  logic [31:0] string_bytes_2_i,
  input  logic [31:0] string_bytes_3_i,
  input  logic [31:0] string_bytes_4_i,
  input  logic [31:0] string_bytes_5_i,
  input  logic [31:0] string_bytes_6_i,
  input  logic [31:0] string_bytes_7_i,
  input  logic        final_group_i,

  // placement and close record items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_kind_o,
  output logic [31:0] bundle_number_o,
  output logic [39:0] row_bit_offset_o,
  output logic [47:0] slab_pos_o,
  output logic [39:0] bundle_rows_o,
  output logic [35:0] mask_words_o,
  output logic [47:0] bundle_bytes_o,
  output logic        last_of_run_o
);

  // configuration registers
  logic [47:0] batch_limit_q;
  logic [31:0] string_limit_q;
  logic [3:0]  active_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_limit_q  <= 48'd268435456;
      string_limit_q <= 32'd2147483647;
      active_cols_q  <= 4'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BATCH_LIMIT:  batch_limit_q  <= cfg_wdata_i;
        CFG_STRING_LIMIT: string_limit_q <= cfg_wdata_i[31:0];
        CFG_ACTIVE_COLS:  active_cols_q  <= cfg_wdata_i[3:0];
        default: begin
          // unlisted index, write dropped
        end
      endcase
    end
  end

  // an item is taken whenever the queue has room
  logic        queue_full;
  logic        take;

  assign in_stall_o = queue_full;
  assign take       = in_valid_i & ~queue_full;

  // string byte columns gathered for the lanes
  logic [31:0] string_bytes [NumStringPorts];

  assign string_bytes[0] = string_bytes_0_i;
  assign string_bytes[1] = string_bytes_1_i;
  assign string_bytes[2] = string_bytes_2_i;
  assign string_bytes[3] = string_bytes_3_i;
  assign string_bytes[4] = string_bytes_4_i;
  assign string_bytes[5] = string_bytes_5_i;
  assign string_bytes[6] = string_bytes_6_i;
  assign string_bytes[7] = string_bytes_7_i;

  // one lane per column: running string sum and its limit check
  lane_ctrl_t             lane_ctrl;
  logic [MAX_COLUMNS-1:0] lane_hit;

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_lane
    rgbp_lane u_lane (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .string_bytes_i (string_bytes[c]),
      .string_limit_i (string_limit_q),
      .ctrl_i         (lane_ctrl),
      .hit_o          (lane_hit[c])
    );
  end

  // merge: combines lane hits with the budget check, keeps the bundle sums
  bundle_set_t set;

  rgbp_merge #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .decoded_bytes_i (decoded_bytes_i),
    .group_rows_i    (group_rows_i),
    .staging_bytes_i (staging_bytes_i),
    .final_group_i   (final_group_i),
    .batch_limit_i   (batch_limit_q),
    .active_cols_i   (active_cols_q),
    .lane_hit_i      (lane_hit),
    .lane_ctrl_o     (lane_ctrl),
    .set_o           (set)
  );

  // queue of decided items and the record sequencer with its output register
  rgbp_out u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (take),
    .set_i            (set),
    .full_o           (queue_full),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .record_kind_o    (record_kind_o),
    .bundle_number_o  (bundle_number_o),
    .row_bit_offset_o (row_bit_offset_o),
    .slab_pos_o       (slab_pos_o),
    .bundle_rows_o    (bundle_rows_o),
    .mask_words_o     (mask_words_o),
    .bundle_bytes_o   (bundle_bytes_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

### dv/testbench.sv
module testbench import rgbp_pkg::*; ();

  localparam logic [23:0] Max24 = {24{1'b1}};
  localparam logic [31:0] Max32 = {32{1'b1}};
  localparam logic [1:0] CfgUnusedIdx = 2'd3;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned LongBundleGroups = 8;

  // one row-group descriptor as it crosses the input port
  typedef struct packed {
    logic [31:0]      dec;
    logic [23:0]      rows;
    logic [31:0]      stag;
    logic [7:0][31:0] sb;
    logic             fin;
  } group_t;

  // one placement or close record
  typedef struct packed {
    logic        kind;
    logic [31:0] bundle;
    logic [39:0] row_off;
    logic [47:0] slab_off;
    logic [39:0] rows;
    logic [35:0] words;
    logic [47:0] bytes;
    logic        last;
  } bundle_rec_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [47:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] decoded_bytes_i = '0;
  logic [23:0] group_rows_i = '0;
  logic [31:0] staging_bytes_i = '0;
  logic [31:0] string_bytes_0_i = '0;
  logic [31:0] string_bytes_1_i = '0;
  logic [31:0] string_bytes_2_i = '0;
  logic [31:0] string_bytes_3_i = '0;
  logic [31:0] string_bytes_4_i = '0;
  logic [31:0] string_bytes_5_i = '0;
  logic [31:0] string_bytes_6_i = '0;
  logic [31:0] string_bytes_7_i = '0;
  logic        final_group_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        record_kind_o;
  logic [31:0] bundle_number_o;
  logic [39:0] row_bit_offset_o;
  logic [47:0] slab_pos_o;
  logic [39:0] bundle_rows_o;
  logic [35:0] mask_words_o;
  logic [47:0] bundle_bytes_o;
  logic        last_of_run_o;

  row_group_bundle_packer_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .decoded_bytes_i  (decoded_bytes_i),
    .group_rows_i     (group_rows_i),
    .staging_bytes_i  (staging_bytes_i),
    .string_bytes_0_i (string_bytes_0_i),
    .string_bytes_1_i (string_bytes_1_i),
    .string_bytes_2_i (string_bytes_2_i),
    .string_bytes_3_i (string_bytes_3_i),
    .string_bytes_4_i (string_bytes_4_i),
    .string_bytes_5_i (string_bytes_5_i),
    .string_bytes_6_i (string_bytes_6_i),
    .string_bytes_7_i (string_bytes_7_i),
    .final_group_i    (final_group_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .record_kind_o    (record_kind_o),
    .bundle_number_o  (bundle_number_o),
    .row_bit_offset_o (row_bit_offset_o),
    .slab_pos_o       (slab_pos_o),
    .bundle_rows_o    (bundle_rows_o),
    .mask_words_o     (mask_words_o),
    .bundle_bytes_o   (bundle_bytes_o),
    .last_of_run_o    (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // packing predictor: limits, open bundle sums and bundle counter
  // ---------------------------------------------------------------------------
  logic [47:0] batch_lim = 48'd268435456;
  logic [31:0] string_lim = 32'd2147483647;
  logic [3:0]  act_cols = 4'd8;

  logic        bundle_open = 1'b0;
  logic [47:0] budget_sum = '0;
  logic [39:0] row_sum = '0;
  logic [47:0] slab_sum = '0;
  logic [32:0] str_sum [8];
  logic [31:0] bundle_cnt = '0;

  bundle_rec_t pending_records[$];
  int          error_count = 0;

  initial foreach (str_sum[c]) str_sum[c] = '0;

  // round a byte count up to the slab alignment
  function automatic logic [63:0] align_slab(input logic [63:0] v);
    return (v + 64'(SlabAlign - 1)) & ~64'(SlabAlign - 1);
  endfunction

  // close record of the open bundle, then empty the bundle
  function automatic bundle_rec_t close_bundle();
    bundle_rec_t r;
    logic [63:0] words;
    logic [63:0] bytes;
    words = (64'(row_sum) + 64'd31) / 64'd32;
    bytes = align_slab(64'(slab_sum)) + words * 64'd4;
    r = '0;
    r.kind   = KindClose;
    r.bundle = bundle_cnt;
    r.rows   = row_sum;
    r.words  = words[35:0];
    r.bytes  = (bytes > 64'(Max48)) ? Max48 : bytes[47:0];
    bundle_cnt  = bundle_cnt + 32'd1;
    bundle_open = 1'b0;
    budget_sum  = '0;
    row_sum     = '0;
    slab_sum    = '0;
    foreach (str_sum[c]) str_sum[c] = '0;
    return r;
  endfunction

  // records caused by one accepted group: optional cut, placement, optional close
  function automatic void pack_group(input group_t g);
    bundle_rec_t recs[$];
    bundle_rec_t r;
    logic        cut;
    logic [63:0] t;
    int          cols;
    cols = (act_cols > 4'd8) ? 8 : int'(act_cols);
    if (bundle_open) begin
      cut = (64'(budget_sum) + 64'(g.dec)) > 64'(batch_lim);
      for (int c = 0; c < cols; c++)
        if (64'(str_sum[c]) + 64'(g.sb[c]) >= 64'(string_lim)) cut = 1'b1;
      if (cut) recs = {recs, close_bundle()};
    end
    r = '0;
    r.kind     = KindPlace;
    r.bundle   = bundle_cnt;
    r.row_off  = row_sum;
    r.slab_off = slab_sum;
    recs = {recs, r};
    bundle_open = 1'b1;
    t = 64'(budget_sum) + 64'(g.dec);
    budget_sum = (t > 64'(Max48)) ? Max48 : t[47:0];
    t = 64'(row_sum) + 64'(g.rows);
    row_sum = (t > 64'(Max40)) ? Max40 : t[39:0];
    // staging space is aligned per group, saturated value may be unaligned
    t = align_slab(64'(slab_sum) + 64'(g.stag));
    slab_sum = (t > 64'(Max48)) ? Max48 : t[47:0];
    // every column keeps counting, active or not
    foreach (str_sum[c]) begin
      t = 64'(str_sum[c]) + 64'(g.sb[c]);
      str_sum[c] = (t > 64'(Max33)) ? Max33 : t[32:0];
    end
    if (row_sum[2:0] != 3'd0 || g.fin) recs = {recs, close_bundle()};
    // bundle numbers restart with each request
    if (g.fin) bundle_cnt = '0;
    recs[recs.size() - 1].last = 1'b1;
    pending_records = {pending_records, recs};
  endfunction

  // ---------------------------------------------------------------------------
  // record checker
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    bundle_rec_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_records.size() == 0) begin
        $error("record with nothing expected: kind %0b bundle %0d",
               record_kind_o, bundle_number_o);
        error_count++;
      end else begin
        e = pending_records.pop_front();
        check_field("record_kind", 64'(e.kind), 64'(record_kind_o));
        check_field("bundle_number", 64'(e.bundle), 64'(bundle_number_o));
        check_field("row_bit_offset", 64'(e.row_off), 64'(row_bit_offset_o));
        check_field("slab_offset", 64'(e.slab_off), 64'(slab_pos_o));
        check_field("bundle_rows", 64'(e.rows), 64'(bundle_rows_o));
        check_field("mask_words", 64'(e.words), 64'(mask_words_o));
        check_field("bundle_bytes", 64'(e.bytes), 64'(bundle_bytes_o));
        check_field("last_of_run", 64'(e.last), 64'(last_of_run_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output stall pattern: free runs, light and heavy stalling, toggling
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(3, 0);
      stall_left = $urandom_range(200, 20);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(3, 0) == 0);
      2: out_stall_i <= ($urandom_range(3, 0) != 0);
      default: out_stall_i <= ~out_stall_i;
    endcase
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any item moving on either side
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("FAIL row_group_bundle_packer_core");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender: bursts of back-to-back items separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  bit steady_sender = 1'b0;

  task automatic send_group(input group_t g);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(20, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0 && !steady_sender) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    decoded_bytes_i  <= g.dec;
    group_rows_i     <= g.rows;
    staging_bytes_i  <= g.stag;
    string_bytes_0_i <= g.sb[0];
    string_bytes_1_i <= g.sb[1];
    string_bytes_2_i <= g.sb[2];
    string_bytes_3_i <= g.sb[3];
    string_bytes_4_i <= g.sb[4];
    string_bytes_5_i <= g.sb[5];
    string_bytes_6_i <= g.sb[6];
    string_bytes_7_i <= g.sb[7];
    final_group_i    <= g.fin;
    do @(posedge clk_i); while (in_stall_o);
    pack_group(g);
  endtask

  function automatic group_t mk_group(input logic [31:0] dec, input logic [23:0] rows,
                                      input logic [31:0] stag, input logic [31:0] sb_all,
                                      input logic fin);
    group_t g;
    g.dec  = dec;
    g.rows = rows;
    g.stag = stag;
    foreach (g.sb[c]) g.sb[c] = sb_all;
    g.fin  = fin;
    return g;
  endfunction

  // register writes only once every record is out and the block has settled
  task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
    in_valid_i <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BATCH_LIMIT:  batch_lim = value;
      CFG_STRING_LIMIT: string_lim = value[31:0];
      CFG_ACTIVE_COLS:  act_cols = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [47:0] batch, input logic [31:0] str,
                            input logic [3:0] cols);
    write_reg(CFG_BATCH_LIMIT, batch);
    write_reg(CFG_STRING_LIMIT, 48'(str));
    write_reg(CFG_ACTIVE_COLS, 48'(cols));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset limits: empty group, budget cut, string cut, odd rows, extreme fields
  task automatic test_reset_limits();
    group_t g;
    send_group(mk_group('0, '0, '0, '0, 1'b0));
    send_group(mk_group(32'd100, 24'd8, 32'd1, '0, 1'b0));
    send_group(mk_group(Max32, 24'd16, 32'd63, '0, 1'b0));
    send_group(mk_group(32'd5, 24'd24, 32'd64, 32'h7FFF_FFFE, 1'b0));
    send_group(mk_group(32'd5, 24'd8, '0, 32'd1, 1'b0));
    send_group(mk_group(Max32, Max24, Max32, Max32, 1'b0));
    send_group(mk_group('0, 24'hFFFFF8, Max32, '0, 1'b1));
    // alternating bit patterns, then their inverse
    g = mk_group(32'hAAAA_AAAA, 24'h555550, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    foreach (g.sb[c]) if (c % 2) g.sb[c] = 32'h5555_5555;
    send_group(g);
    g = ~g;
    g.rows = 24'hAAAAA8;
    g.fin  = 1'b1;
    send_group(g);
  endtask

  // zero string limit, zero batch limit, oversized column count, unknown index
  task automatic test_register_corners();
    write_reg(CFG_STRING_LIMIT, '0);
    repeat (2) send_group(mk_group('0, 24'd8, 32'd10, '0, 1'b0));
    send_group(mk_group('0, 24'd8, 32'd10, '0, 1'b1));
    set_limits('0, 32'd1, 4'd15);
    repeat (2) send_group(mk_group('0, 24'd8, 32'd70, '0, 1'b0));
    send_group(mk_group(32'd1, 24'd16, 32'd1, '0, 1'b0));
    send_group(mk_group('0, 24'd8, '0, 32'd1, 1'b1));
    write_reg(CfgUnusedIdx, 48'hFFFF_FFFF_FFFF);
    // inactive columns saturate, switching them on cuts the bundle
    set_limits(Max48, Max32, 4'd0);
    repeat (3) send_group(mk_group(Max32, 24'd8, 32'd3, Max32, 1'b0));
    write_reg(CFG_ACTIVE_COLS, 48'd8);
    send_group(mk_group('0, 24'd8, '0, '0, 1'b1));
  endtask

  // one long bundle of groups with the largest multiple-of-8 row count and the largest staging count
  task automatic test_long_bundle();
    set_limits(Max48, Max32, 4'd0);
    steady_sender = 1'b1;
    for (int i = 1; i <= LongBundleGroups; i++)
      send_group(mk_group('0, 24'hFFFFF8, Max32, '0, i == LongBundleGroups));
    steady_sender = 1'b0;
  endtask

  function automatic group_t random_group(input logic fin);
    group_t      g;
    logic [63:0] dec_span;
    logic [63:0] str_span;
    dec_span = 64'(batch_lim) / 3;
    if (dec_span > 64'(Max32)) dec_span = 64'(Max32);
    str_span = 64'(string_lim) / 4;
    case ($urandom_range(9, 0))
      0: g.dec = '0;
      1: g.dec = Max32;
      2: g.dec = $urandom;
      default: g.dec = $urandom_range(32'(dec_span), 0);
    endcase
    // mostly whole multiples of 8 so bundles span several groups
    case ($urandom_range(9, 0))
      6: g.rows = 24'($urandom_range(255, 0));
      7: g.rows = 24'($urandom);
      8: g.rows = 24'hFFFFF8;
      9: g.rows = '0;
      default: g.rows = 24'(8 * $urandom_range(64, 0));
    endcase
    g.stag = ($urandom_range(7, 0) == 0) ? $urandom : $urandom_range(300, 0);
    foreach (g.sb[c]) begin
      case ($urandom_range(9, 0))
        7: g.sb[c] = '0;
        8: g.sb[c] = $urandom;
        9: g.sb[c] = Max32;
        default: g.sb[c] = $urandom_range(32'(str_span), 0);
      endcase
    end
    // a stray request end now and then
    g.fin = fin || ($urandom_range(19, 0) == 0);
    return g;
  endfunction

  // requests of random length under a series of limit settings
  task automatic test_random_requests();
    int          sent;
    int          len;
    logic [47:0] batch;
    logic [31:0] str;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_limits(48'd4096, 32'd1000, 4'd3);
        1: set_limits(Max48, Max32, 4'd8);
        2: set_limits('0, 32'd1, 4'd15);
        default: begin
          case ($urandom_range(4, 0))
            0: batch = 48'($urandom_range(4095, 0));
            1: batch = 48'($urandom);
            2: batch = {16'($urandom), 32'($urandom)};
            3: batch = Max48;
            default: batch = '0;
          endcase
          case ($urandom_range(4, 0))
            0: str = $urandom_range(2000, 1);
            1: str = $urandom;
            2: str = Max32;
            3: str = '0;
            default: str = $urandom_range(100000, 1);
          endcase
          set_limits(batch, str, 4'($urandom_range(15, 0)));
        end
      endcase
      sent = 0;
      while (sent < 58) begin
        len = $urandom_range(16, 1);
        for (int i = 0; i < len; i++) send_group(random_group(i == len - 1));
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_limits();
    test_register_corners();
    test_long_bundle();
    test_random_requests();
    in_valid_i <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && pending_records.size() == 0) begin
      $display("PASS row_group_bundle_packer_core");
    end else begin
      $display("FAIL row_group_bundle_packer_core");
    end
    $finish;
  end

endmodule

### sim.f
sv/rgbp_pkg.sv
sv/rgbp_lane.sv
sv/rgbp_merge.sv
sv/rgbp_out.sv
sv/row_group_bundle_packer_core.sv
dv/testbench.sv
